@@ sv/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package wsd_pkg;
    localparam int LEN_W  = 63;
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [2:0] EXT16_BYTES = 3'd1;
    localparam logic [2:0] EXT64_BYTES = 3'd7;
    localparam logic [2:0] KEY_BYTES   = 3'd3;

    typedef struct packed {
        logic [7:0]       data;
        logic [7:0]       key_byte;
        logic             fin;
        logic [3:0]       opcode;
        logic             first;
        logic             last;
        logic [LEN_W-1:0] length;
    } t_item;
endpackage

@@ sv/websocket_frame_deframer_core.sv @@
// WebSocket frame deframer top level: parser, queue and output stage.
// Accepts one stream byte per cycle unless a full queue stalls payload input; header bytes give no result.
// A payload byte is first registered in the queue, then popped into the output register.
// Throughput is one byte per cycle while not stalled, set by the single-byte parser state update.
// Synchronous active-low reset returns the parser to the control byte, empties the queue.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
`timescale 1ns / 1ps
module websocket_frame_deframer_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_stream_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_payload_byte,
    output logic                      o_final_fragment,
    output logic [3:0]                o_frame_opcode,
    output logic                      o_first_of_frame,
    output logic                      o_end_of_frame,
    output logic [wsd_pkg::LEN_W-1:0] o_frame_length
);
    import wsd_pkg::*;

    logic  push, q_full, pop, q_valid;
    t_item push_item, q_item;

    wsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_stream_byte(i_stream_byte),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    wsd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_item (q_item)
    );

    wsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_final_fragment(o_final_fragment),
        .o_frame_opcode  (o_frame_opcode),
        .o_first_of_frame(o_first_of_frame),
        .o_end_of_frame  (o_end_of_frame),
        .o_frame_length  (o_frame_length)
    );
endmodule

@@ sv/wsd_front.sv @@
// Header parser: accepts stream bytes, tracks frame header state and
// pushes tagged payload bytes into the queue. Depends on wsd_pkg.
`timescale 1ns / 1ps
module wsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_stream_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output wsd_pkg::t_item o_item
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_CTRL = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_masked, n_masked;
    logic [2:0]       r_hcnt, n_hcnt;
    logic [LEN_W-1:0] r_len, n_len;
    logic [31:0]      r_key, n_key;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [1:0]       r_kidx, n_kidx;

    logic             accept;
    logic             ld_go;
    logic             ld_masked;
    logic [LEN_W-1:0] ld_len;
    logic [LEN_W-1:0] ext_len;
    logic [7:0]       kb;
    logic             first, last;

    assign o_in_stall = (r_phase == PH_DATA) && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign ext_len    = {r_len[LEN_W-9:0], i_stream_byte};
    assign first      = (r_rem == r_len);
    assign last       = (r_rem[LEN_W-1:1] == '0);

    always_comb begin
        case (r_kidx)
            2'd0:    kb = r_key[31:24];
            2'd1:    kb = r_key[23:16];
            2'd2:    kb = r_key[15:8];
            default: kb = r_key[7:0];
        endcase
        if (!r_masked) begin
            kb = 8'h00;
        end
    end

    assign o_push        = accept && (r_phase == PH_DATA);
    assign o_item.data     = i_stream_byte;
    assign o_item.key_byte = kb;
    assign o_item.fin      = r_fin;
    assign o_item.opcode   = r_opcode;
    assign o_item.first    = first;
    assign o_item.last     = last;
    assign o_item.length   = r_len;

    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_masked  = r_masked;
        n_hcnt    = r_hcnt;
        n_len     = r_len;
        n_key     = r_key;
        n_rem     = r_rem;
        n_kidx    = r_kidx;
        ld_go     = 1'b0;
        ld_masked = r_masked;
        ld_len    = r_len;
        if (accept) begin
            case (r_phase)
                PH_CTRL: begin
                    n_fin    = i_stream_byte[7];
                    n_opcode = i_stream_byte[3:0];
                    n_phase  = PH_LEN;
                end
                PH_LEN: begin
                    n_masked  = i_stream_byte[7];
                    n_len     = '0;
                    ld_masked = i_stream_byte[7];
                    if (i_stream_byte[6:0] == LEN_EXT16) begin
                        n_hcnt  = EXT16_BYTES;
                        n_phase = PH_EXT;
                    end else if (i_stream_byte[6:0] == LEN_EXT64) begin
                        n_hcnt  = EXT64_BYTES;
                        n_phase = PH_EXT;
                    end else begin
                        ld_len = {{(LEN_W-7){1'b0}}, i_stream_byte[6:0]};
                        n_len  = ld_len;
                        ld_go  = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_len = ext_len;
                    if (r_hcnt == 3'd0) begin
                        ld_len = ext_len;
                        ld_go  = 1'b1;
                    end else begin
                        n_hcnt = r_hcnt - 3'd1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], i_stream_byte};
                    if (r_hcnt == 3'd0) begin
                        n_phase = (r_len != '0) ? PH_DATA : PH_CTRL;
                    end else begin
                        n_hcnt = r_hcnt - 3'd1;
                    end
                end
                PH_DATA: begin
                    n_kidx = r_kidx + 2'd1;
                    if (last) begin
                        n_rem   = '0;
                        n_phase = PH_CTRL;
                    end else begin
                        n_rem = r_rem - {{(LEN_W-1){1'b0}}, 1'b1};
                    end
                end
                default: begin
                    n_phase = PH_CTRL;
                end
            endcase
            if (ld_go) begin
                n_rem  = ld_len;
                n_kidx = 2'd0;
                if (ld_masked) begin
                    n_hcnt  = KEY_BYTES;
                    n_key   = '0;
                    n_phase = PH_KEY;
                end else if (ld_len != '0) begin
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_CTRL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CTRL;
            r_fin    <= 1'b0;
            r_opcode <= '0;
            r_masked <= 1'b0;
            r_hcnt   <= '0;
            r_len    <= '0;
            r_key    <= '0;
            r_rem    <= '0;
            r_kidx   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_hcnt   <= n_hcnt;
            r_len    <= n_len;
            r_key    <= n_key;
            r_rem    <= n_rem;
            r_kidx   <= n_kidx;
        end
    end
endmodule

@@ sv/wsd_queue.sv @@
// Short register queue between the header parser and the output stage.
// Depends on wsd_pkg for the item type and depth.
`timescale 1ns / 1ps
module wsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output wsd_pkg::t_item o_item
);
    import wsd_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ sv/wsd_back.sv @@
// Output stage: unmasks queued payload bytes into the result register.
// Depends on wsd_pkg for the item type.
`timescale 1ns / 1ps
module wsd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  wsd_pkg::t_item            i_q_item,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_payload_byte,
    output logic                      o_final_fragment,
    output logic [3:0]                o_frame_opcode,
    output logic                      o_first_of_frame,
    output logic                      o_end_of_frame,
    output logic [wsd_pkg::LEN_W-1:0] o_frame_length
);
    import wsd_pkg::*;

    logic r_valid, n_valid;

    assign o_pop       = i_q_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_payload_byte   <= i_q_item.data ^ i_q_item.key_byte;
            o_final_fragment <= i_q_item.fin;
            o_frame_opcode   <= i_q_item.opcode;
            o_first_of_frame <= i_q_item.first;
            o_end_of_frame   <= i_q_item.last;
            o_frame_length   <= i_q_item.length;
        end
    end
endmodule
